### rtl/core/aefs_pkg.sv
// ----------------------------------------------------------------------------
// aefs_pkg
// shared types and constants of the address entry frame sender
// ----------------------------------------------------------------------------
package aefs_pkg;

  localparam int DIGIT_COUNT = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  FRAME_HEAD    = 8'h05;
  localparam logic [7:0]  FRAME_MARK    = 8'h5a;
  localparam logic [15:0] DISPLAY_RESET = 16'd10;

  localparam logic        OP_TICK    = 1'b1;
  localparam logic [3:0]  KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0]  KEY_ENTER  = 4'd10;
  localparam logic [3:0]  KEY_ESCAPE = 4'd11;

  localparam logic [2:0]  SLOT_HEAD    = 3'd0;
  localparam logic [2:0]  SLOT_SECTION = 3'd1;
  localparam logic [2:0]  SLOT_ROOM    = 3'd2;
  localparam logic [2:0]  SLOT_BED     = 3'd3;
  localparam logic [2:0]  SLOT_MARK    = 3'd4;
  localparam logic [2:0]  SLOT_SUM     = 3'd5;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [1:0] entry_stage;
    digit_t     hundreds;
    digit_t     tens;
    digit_t     ones;
    logic       lit;
    logic       is_frame;
    logic [7:0] section;
    logic [7:0] room;
    logic [7:0] bed;
  } aefs_job_t;

endpackage

### rtl/core/aefs_front.sv
// ----------------------------------------------------------------------------
// aefs_front
// accepts key and tick words, updates entry state and queues one job per word
// ----------------------------------------------------------------------------
module aefs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  input  logic                in_operation,
  input  logic [3:0]          in_key_code,
  input  logic                q_full,
  output logic                push,
  output aefs_pkg::aefs_job_t push_job
);
  import aefs_pkg::*;

  typedef enum logic [1:0] {
    STAGE_SECTION = 2'd0,
    STAGE_ROOM    = 2'd1,
    STAGE_BED     = 2'd2
  } stage_t;

  stage_t      stage_r, stage_nxt;
  digit_t      digits_r   [DIGIT_COUNT];
  digit_t      digits_nxt [DIGIT_COUNT];
  logic [7:0]  section_r, section_nxt;
  logic [7:0]  room_r, room_nxt;
  logic [7:0]  bed_r, bed_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic [15:0] on_secs_r;
  logic [7:0]  fold;
  logic        is_frame;

  assign push = in_valid && !q_full;

  always_comb begin
    fold = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      fold = 8'(fold * 8'd10) + {4'd0, digits_r[i]};
    end
  end

  always_comb begin
    stage_nxt     = stage_r;
    digits_nxt    = digits_r;
    section_nxt   = section_r;
    room_nxt      = room_r;
    bed_nxt       = bed_r;
    countdown_nxt = countdown_r;
    is_frame      = 1'b0;
    if (in_operation == OP_TICK) begin
      if (countdown_r != '0) begin
        countdown_nxt = countdown_r - 16'd1;
      end
    end else if (countdown_r == '0) begin
      // wake-up key
      stage_nxt     = STAGE_SECTION;
      digits_nxt    = '{default: '0};
      section_nxt   = '0;
      room_nxt      = '0;
      bed_nxt       = '0;
      countdown_nxt = on_secs_r;
    end else begin
      countdown_nxt = on_secs_r;
      if (in_key_code <= KEY_DIGIT_MAX) begin
        for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
          digits_nxt[i] = digits_r[i + 1];
        end
        digits_nxt[DIGIT_COUNT - 1] = in_key_code;
      end else if (in_key_code == KEY_ENTER) begin
        digits_nxt = '{default: '0};
        unique case (stage_r)
          STAGE_SECTION: begin
            section_nxt = fold;
            stage_nxt   = STAGE_ROOM;
          end
          STAGE_ROOM: begin
            room_nxt  = fold;
            stage_nxt = STAGE_BED;
          end
          default: begin
            bed_nxt   = fold;
            stage_nxt = STAGE_SECTION;
            is_frame  = 1'b1;
          end
        endcase
      end else if (in_key_code == KEY_ESCAPE) begin
        stage_nxt   = STAGE_SECTION;
        digits_nxt  = '{default: '0};
        section_nxt = '0;
        room_nxt    = '0;
        bed_nxt     = '0;
      end
    end
  end

  always_comb begin
    push_job.entry_stage = stage_nxt;
    push_job.ones        = digits_nxt[DIGIT_COUNT - 1];
    push_job.tens        = (DIGIT_COUNT > 1) ? digits_nxt[(DIGIT_COUNT > 1) ? DIGIT_COUNT - 2 : 0]
                                             : '0;
    push_job.hundreds    = (DIGIT_COUNT > 2) ? digits_nxt[(DIGIT_COUNT > 2) ? DIGIT_COUNT - 3 : 0]
                                             : '0;
    push_job.lit         = (countdown_nxt != '0);
    push_job.is_frame    = is_frame;
    push_job.section     = section_nxt;
    push_job.room        = room_nxt;
    push_job.bed         = bed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_secs_r <= DISPLAY_RESET;
    end else if (cfg_we) begin
      on_secs_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= STAGE_SECTION;
      digits_r    <= '{default: '0};
      section_r   <= '0;
      room_r      <= '0;
      bed_r       <= '0;
      countdown_r <= DISPLAY_RESET;
    end else if (push) begin
      stage_r     <= stage_nxt;
      digits_r    <= digits_nxt;
      section_r   <= section_nxt;
      room_r      <= room_nxt;
      bed_r       <= bed_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  stage_never_three: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r != 2'd3)
    else $error("entry stage out of range");

  frame_leaves_section: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_job.is_frame |=> stage_r == STAGE_SECTION)
    else $error("frame job did not restart entry");

  frame_only_from_bed: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_job.is_frame |-> stage_r == STAGE_BED)
    else $error("frame job outside bed stage");

endmodule

### rtl/core/aefs_queue.sv
// ----------------------------------------------------------------------------
// aefs_queue
// short job queue between the entry front and the frame sender back
// ----------------------------------------------------------------------------
module aefs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  aefs_pkg::aefs_job_t push_job,
  input  logic                pop,
  output aefs_pkg::aefs_job_t head_job,
  output logic                full,
  output logic                empty
);
  import aefs_pkg::*;

  aefs_job_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;

  assign full     = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue overflow");

  no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue underflow");

  count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    QUEUE_AW'(wr_ptr_r - rd_ptr_r) == QUEUE_AW'(count_r))
    else $error("queue count out of step with pointers");

endmodule

### rtl/core/aefs_back.sv
// ----------------------------------------------------------------------------
// aefs_back
// takes queued jobs and emits one status word, or six frame byte words
// ----------------------------------------------------------------------------
module aefs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  aefs_pkg::aefs_job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_entry_stage,
  output logic [3:0]          out_digit_hundreds,
  output logic [3:0]          out_digit_tens,
  output logic [3:0]          out_digit_ones,
  output logic                out_display_lit,
  output logic                out_byte_valid,
  output logic [7:0]          out_frame_byte,
  output logic                out_last
);
  import aefs_pkg::*;

  aefs_job_t  job_r;
  logic [7:0] sum_r;
  logic       busy_r;
  logic [2:0] slot_r;
  logic       take;

  assign out_valid = busy_r;
  assign take      = busy_r && !out_stall;
  assign out_last  = !job_r.is_frame || (slot_r == SLOT_SUM);
  assign pop       = !q_empty && (!busy_r || (take && out_last));

  assign out_entry_stage    = job_r.entry_stage;
  assign out_digit_hundreds = job_r.hundreds;
  assign out_digit_tens     = job_r.tens;
  assign out_digit_ones     = job_r.ones;
  assign out_display_lit    = job_r.lit;
  assign out_byte_valid     = job_r.is_frame;

  always_comb begin
    out_frame_byte = '0;
    if (job_r.is_frame) begin
      case (slot_r)
        SLOT_HEAD:    out_frame_byte = FRAME_HEAD;
        SLOT_SECTION: out_frame_byte = job_r.section;
        SLOT_ROOM:    out_frame_byte = job_r.room;
        SLOT_BED:     out_frame_byte = job_r.bed;
        SLOT_MARK:    out_frame_byte = FRAME_MARK;
        default:      out_frame_byte = sum_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head_job;
      sum_r <= FRAME_HEAD + head_job.section + head_job.room + head_job.bed + FRAME_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= SLOT_HEAD;
    end else if (pop) begin
      busy_r <= 1'b1;
      slot_r <= SLOT_HEAD;
    end else if (take) begin
      if (out_last) begin
        busy_r <= 1'b0;
      end else begin
        slot_r <= slot_r + 3'd1;
      end
    end
  end

  slot_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && slot_r != SLOT_HEAD |-> job_r.is_frame)
    else $error("frame slot advanced on a status job");

  slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_SUM)
    else $error("frame slot past checksum");

  stall_holds_slot: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_stall |=> busy_r && $stable(slot_r))
    else $error("frame slot moved while stalled");

endmodule

### rtl/core/address_entry_frame_sender_unit.sv
// ----------------------------------------------------------------------------
// address_entry_frame_sender_unit
// keypad address entry with six-byte frame output
// ----------------------------------------------------------------------------
// an input word is first written to the job queue; its result word is valid
//   once the back stage has it in its job register (empty queue, free output)
// throughput: one input word per cycle while the four-deep job queue is not
//   full; output sends one word per cycle unless stalled, six for a frame job
// reset: synchronous, active low; entry restarts at section, countdown and
//   reload value become 10, queue and output are emptied
module address_entry_frame_sender_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [3:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_entry_stage,
  output logic [3:0]  out_digit_hundreds,
  output logic [3:0]  out_digit_tens,
  output logic [3:0]  out_digit_ones,
  output logic        out_display_lit,
  output logic        out_byte_valid,
  output logic [7:0]  out_frame_byte,
  output logic        out_last
);
  import aefs_pkg::*;

  aefs_job_t push_job;
  aefs_job_t head_job;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  assign in_stall = q_full;

  aefs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_key_code  (in_key_code),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  aefs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  aefs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .head_job           (head_job),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entry_stage    (out_entry_stage),
    .out_digit_hundreds (out_digit_hundreds),
    .out_digit_tens     (out_digit_tens),
    .out_digit_ones     (out_digit_ones),
    .out_display_lit    (out_display_lit),
    .out_byte_valid     (out_byte_valid),
    .out_frame_byte     (out_frame_byte),
    .out_last           (out_last)
  );

endmodule

### dv/frame_sender_checker.sv
// ----------------------------------------------------------------------------
// frame_sender_checker
// watches the key/tick and frame byte channels of the address entry frame
// sender, predicts every result word from its own copy of the entry state,
// and compares each accepted result word field by field in order
// ----------------------------------------------------------------------------
module frame_sender_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_operation,
  input  logic [3:0]  in_key_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_entry_stage,
  input  logic [3:0]  out_digit_hundreds,
  input  logic [3:0]  out_digit_tens,
  input  logic [3:0]  out_digit_ones,
  input  logic        out_display_lit,
  input  logic        out_byte_valid,
  input  logic [7:0]  out_frame_byte,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          words_checked,
  output int          frames_sent
);
  import aefs_pkg::*;

  localparam logic [1:0] STAGE_SECTION = 2'd0;
  localparam logic [1:0] STAGE_ROOM    = 2'd1;
  localparam logic [1:0] STAGE_BED     = 2'd2;

  typedef struct packed {
    logic [1:0] entry_stage;
    digit_t     hundreds;
    digit_t     tens;
    digit_t     ones;
    logic       lit;
    logic       byte_valid;
    logic [7:0] frame_byte;
    logic       last;
  } result_word_t;

  result_word_t expected_words[$];
  result_word_t want;

  logic [15:0] reload_seconds;
  logic [15:0] countdown;
  logic [1:0]  entry_stage;
  digit_t      digit_reg [DIGIT_COUNT];
  logic [7:0]  section_addr;
  logic [7:0]  room_addr;
  logic [7:0]  bed_addr;

  int mismatch_total = 0;
  int checked_total  = 0;
  int frame_total    = 0;

  assign fail_count    = mismatch_total;
  assign words_checked = checked_total;
  assign frames_sent   = frame_total;

  task automatic clear_entry();
    entry_stage  = STAGE_SECTION;
    for (int i = 0; i < DIGIT_COUNT; i++) digit_reg[i] = '0;
    section_addr = '0;
    room_addr    = '0;
    bed_addr     = '0;
  endtask

  task automatic push_word(logic valid, logic [7:0] value, logic is_last);
    result_word_t w;
    w.entry_stage = entry_stage;
    w.hundreds    = digit_reg[0];
    w.tens        = digit_reg[1];
    w.ones        = digit_reg[2];
    w.lit         = (countdown != 0);
    w.byte_valid  = valid;
    w.frame_byte  = valid ? value : 8'd0;
    w.last        = is_last;
    expected_words.push_back(w);
  endtask

  task automatic apply_word(logic op, logic [3:0] key);
    logic [31:0] folded;
    logic [7:0]  frame [6];
    logic        sent_frame;
    sent_frame = 1'b0;
    if (op == OP_TICK) begin
      if (countdown != 0) countdown--;
    end else if (countdown == 0) begin
      // dark display: key only wakes it and restarts entry
      clear_entry();
      countdown = reload_seconds;
    end else begin
      countdown = reload_seconds;
      if (key <= KEY_DIGIT_MAX) begin
        for (int i = 0; i + 1 < DIGIT_COUNT; i++) digit_reg[i] = digit_reg[i + 1];
        digit_reg[DIGIT_COUNT - 1] = key;
      end else if (key == KEY_ENTER) begin
        folded = 32'(digit_reg[0]) * 100 + 32'(digit_reg[1]) * 10 + 32'(digit_reg[2]);
        for (int i = 0; i < DIGIT_COUNT; i++) digit_reg[i] = '0;
        case (entry_stage)
          STAGE_SECTION: begin
            section_addr = folded[7:0];
            entry_stage  = STAGE_ROOM;
          end
          STAGE_ROOM: begin
            room_addr   = folded[7:0];
            entry_stage = STAGE_BED;
          end
          default: begin
            bed_addr            = folded[7:0];
            entry_stage         = STAGE_SECTION;
            frame[SLOT_HEAD]    = FRAME_HEAD;
            frame[SLOT_SECTION] = section_addr;
            frame[SLOT_ROOM]    = room_addr;
            frame[SLOT_BED]     = bed_addr;
            frame[SLOT_MARK]    = FRAME_MARK;
            frame[SLOT_SUM]     = FRAME_HEAD + section_addr + room_addr + bed_addr
                                  + FRAME_MARK;
            for (int k = 0; k < 6; k++) push_word(1'b1, frame[k], k == SLOT_SUM);
            frame_total++;
            sent_frame = 1'b1;
          end
        endcase
      end else if (key == KEY_ESCAPE) begin
        clear_entry();
      end
    end
    if (!sent_frame) push_word(1'b0, 8'd0, 1'b1);
  endtask

  task automatic compare_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, exp_v, got_v);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reload_seconds = DISPLAY_RESET;
      countdown      = DISPLAY_RESET;
      clear_entry();
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) apply_word(in_operation, in_key_code);
      if (cfg_we) reload_seconds = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected, frame byte %0h", $time,
                   out_frame_byte);
          mismatch_total++;
        end else begin
          want = expected_words.pop_front();
          compare_field("entry_stage", 8'(want.entry_stage), 8'(out_entry_stage));
          compare_field("digit_hundreds", 8'(want.hundreds), 8'(out_digit_hundreds));
          compare_field("digit_tens", 8'(want.tens), 8'(out_digit_tens));
          compare_field("digit_ones", 8'(want.ones), 8'(out_digit_ones));
          compare_field("display_lit", 8'(want.lit), 8'(out_display_lit));
          compare_field("byte_valid", 8'(want.byte_valid), 8'(out_byte_valid));
          compare_field("frame_byte", want.frame_byte, out_frame_byte);
          compare_field("last", 8'(want.last), 8'(out_last));
          checked_total++;
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives key and tick words into the address entry frame sender: a directed
// opening over digits, enter, escape, ignored keys and display timeout, then
// random entry sequences and noise under several display times, with random
// gaps, stalls and one long output hold; the checker does the comparing
// ----------------------------------------------------------------------------
module testbench;
  import aefs_pkg::*;

  localparam logic       OP_KEY          = ~OP_TICK;
  localparam logic [3:0] KEY_IGNORED_MIN = 4'd12;
  localparam int         IDLE_LIMIT      = 1000;
  localparam int         HOLD_CYCLES     = 60;
  localparam int         HOLD_AFTER      = 200;
  localparam int         RANDOM_ITEMS    = 440;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [15:0] cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic        in_operation = 1'b0;
  logic [3:0]  in_key_code  = '0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_entry_stage;
  logic [3:0]  out_digit_hundreds;
  logic [3:0]  out_digit_tens;
  logic [3:0]  out_digit_ones;
  logic        out_display_lit;
  logic        out_byte_valid;
  logic [7:0]  out_frame_byte;
  logic        out_last;

  int fail_count;
  int pending;
  int words_checked;
  int frames_sent;
  int words_sent     = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;
  bit steady         = 1'b0;
  bit hold_done      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  address_entry_frame_sender_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_key_code        (in_key_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entry_stage    (out_entry_stage),
    .out_digit_hundreds (out_digit_hundreds),
    .out_digit_tens     (out_digit_tens),
    .out_digit_ones     (out_digit_ones),
    .out_display_lit    (out_display_lit),
    .out_byte_valid     (out_byte_valid),
    .out_frame_byte     (out_frame_byte),
    .out_last           (out_last)
  );

  frame_sender_checker entry_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_key_code        (in_key_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entry_stage    (out_entry_stage),
    .out_digit_hundreds (out_digit_hundreds),
    .out_digit_tens     (out_digit_tens),
    .out_digit_ones     (out_digit_ones),
    .out_display_lit    (out_display_lit),
    .out_byte_valid     (out_byte_valid),
    .out_frame_byte     (out_frame_byte),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending            (pending),
    .words_checked      (words_checked),
    .frames_sent        (frames_sent)
  );

  task automatic send_word(logic op, logic [3:0] key);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_code  <= key;
    do @(posedge clk); while (!(in_valid && !in_stall));
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_display_time(logic [15:0] seconds);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= seconds;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // section, room and bed entries with occasional ticks and escapes
  task automatic send_entry_sequence();
    int digit_n;
    int s;
    for (s = 0; s < 3; s++) begin
      digit_n = $urandom_range(0, 4);
      repeat (digit_n) begin
        if ($urandom_range(0, 9) == 0) send_word(OP_TICK, 4'($urandom_range(0, 15)));
        send_word(OP_KEY, 4'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 19) == 0) send_word(OP_KEY, KEY_ESCAPE);
      send_word(OP_KEY, KEY_ENTER);
    end
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 3) == 0) send_word(OP_TICK, 4'($urandom_range(0, 15)));
    else send_word(OP_KEY, 4'($urandom_range(0, 15)));
  endtask

  // output side: random stalls per word, one long hold once the queue can fill
  initial begin
    int n;
    wait (rst_n);
    forever begin
      if (!hold_done && words_sent >= HOLD_AFTER) begin
        n = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (steady) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a word moving", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0]  opening_keys [16];
    logic [15:0] phase_times [7];
    int target;
    opening_keys = '{4'd9, 4'd9, 4'd9, KEY_ENTER,
                     4'd2, 4'd5, 4'd5, KEY_ENTER,
                     4'd0, KEY_ENTER,
                     KEY_IGNORED_MIN, 4'd13, 4'd14, 4'd15,
                     4'd1, KEY_ESCAPE};
    phase_times = '{16'hffff, 16'd3, 16'd1, 16'd0, 16'd2, 16'd10, 16'd4};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full frame with wrapping fold, ignored keys, escape
    foreach (opening_keys[i]) send_word(OP_KEY, opening_keys[i]);

    // short display time: timeout, tick while dark, wake-up keys
    write_display_time(16'd1);
    send_word(OP_KEY, 4'd5);
    send_word(OP_TICK, 4'd0);
    send_word(OP_TICK, 4'hf);
    send_word(OP_KEY, 4'd3);
    send_word(OP_KEY, KEY_ENTER);
    send_word(OP_TICK, 4'd0);
    write_display_time(16'd0);
    send_word(OP_KEY, 4'd7);
    send_word(OP_KEY, 4'd8);

    phase_times[6] = 16'($urandom_range(4, 20));
    foreach (phase_times[p]) begin
      write_display_time(phase_times[p]);
      steady = (p % 3 == 1);
      target = words_sent + RANDOM_ITEMS / 7;
      while (words_sent < target) begin
        if ($urandom_range(0, 9) < 7) send_entry_sequence();
        else send_noise();
      end
    end
    steady = 1'b0;

    drain();
    @(negedge clk);
    $display("sent %0d key and tick words under %0d display time settings", words_sent,
             settings_used);
    $display("checked %0d result words including %0d frames", words_checked, frames_sent);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
